// ===== sv/assert_macros.svh =====
// Assertion macros shared by the heading bank guidance RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(label, clk_sig, rstn_sig, ante, cons)
`define ASSERT_NXT(label, clk_sig, rstn_sig, ante, cons)

`endif

`endif

// ===== sv/hpbg_pkg.sv =====
// Package with widths, codes, reset values and types of the heading bank guidance unit.
`default_nettype none

package hpbg_pkg;

    // Field and register widths.
    localparam int BLIM_W     = 13;
    localparam int ILIM_W     = 40;
    localparam int GAIN_W     = 16;
    localparam int RRL_W      = 15;
    localparam int MODE_W     = 3;
    localparam int ROLL_W     = 16;
    localparam int HDG_W      = 15;
    localparam int DT_W       = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    // Datapath widths.
    localparam int ERR_W     = 15;  // wrapped heading error
    localparam int HI_W      = 42;  // heading integral, also before its clamp
    localparam int MC_W      = 42;  // multiplicand of the serial multiplier
    localparam int MP_W      = 16;  // multiplier operand, one bit per cycle
    localparam int PROD_W    = 58;
    localparam int SUM_W     = 58;
    localparam int Q_W       = 32;
    localparam int DES_W     = 14;
    localparam int STEP_W    = 16;
    localparam int LIM_W     = 18;
    localparam int MUL_CNT_W = 4;

    localparam logic [MUL_CNT_W-1:0] MUL_CNT_LAST = MUL_CNT_W'(MP_W - 1);

    // Heading circle in 1/64 degree.
    localparam logic [HDG_W-1:0] FULL_TURN = 15'd23040;
    localparam logic [HDG_W-1:0] HALF_TURN = 15'd11520;

    // Lateral mode codes.
    localparam logic [MODE_W-1:0] MODE_OFF = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HDG = 3'd1;

    // Fixed-point scaling.
    localparam int PROP_SHIFT = 16;
    localparam int Q_SHIFT    = 26;
    localparam logic signed [SUM_W-1:0] Q_ROUND = SUM_W'(64'd1 << 25);
    localparam logic [31:0] STEP_ROUND = 32'd32768;

    // Largest bank reference magnitude once engaged (13-bit bank limit).
    localparam logic signed [ROLL_W-1:0] BANK_REF_MAX = 16'sd8191;
    localparam logic signed [ROLL_W-1:0] BANK_REF_MIN = -16'sd8191;

    // Register reset values.
    localparam logic [BLIM_W-1:0] BLIM_RESET = 13'd6434;
    localparam logic [ILIM_W-1:0] ILIM_RESET = 40'd125829120;
    localparam logic [GAIN_W-1:0] KP_RESET   = 16'd1311;
    localparam logic [GAIN_W-1:0] KI_RESET   = 16'd66;
    localparam logic [RRL_W-1:0]  RRL_RESET  = 15'd1430;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BANK_LIMIT     = 3'd0,
        CFG_INTEGRAL_LIMIT = 3'd1,
        CFG_GAIN_PROP      = 3'd2,
        CFG_GAIN_INTEG     = 3'd3,
        CFG_ROLL_RATE      = 3'd4
    } cfg_idx_t;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_PREP   = 11'b000_0000_0010,
        S_MUL_ED = 11'b000_0000_0100,
        S_ICLAMP = 11'b000_0000_1000,
        S_MUL_PE = 11'b000_0001_0000,
        S_MUL_IH = 11'b000_0010_0000,
        S_RND    = 11'b000_0100_0000,
        S_DCLAMP = 11'b000_1000_0000,
        S_MUL_ST = 11'b001_0000_0000,
        S_LIMIT  = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

`default_nettype wire

// ===== sv/hpbg_serial_mul.sv =====
// Bit-serial multiplier: signed multiplicand times unsigned 16-bit operand, one bit per cycle.
`default_nettype none
`include "assert_macros.svh"

module hpbg_serial_mul (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [hpbg_pkg::MC_W-1:0]    mcand,
    input  logic        [hpbg_pkg::MP_W-1:0]    mplier,
    output hpbg_pkg::mul_stat_t                 stat,
    output logic signed [hpbg_pkg::PROD_W-1:0]  product
);
    import hpbg_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [MUL_CNT_W-1:0]   cnt_reg;
    logic signed [MC_W-1:0] mcand_reg;
    logic signed [MC_W:0]   acc_hi_reg;
    logic [MP_W-1:0]        acc_lo_reg;
    logic signed [MC_W:0]   partial;

    // Add the multiplicand when the current multiplier bit is set, then shift right.
    assign partial = acc_hi_reg + (acc_lo_reg[0] ? (MC_W + 1)'(mcand_reg) : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MUL_CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= mcand;
            acc_hi_reg <= '0;
            acc_lo_reg <= mplier;
        end
        else if (busy_reg)
        begin
            acc_hi_reg <= {partial[MC_W], partial[MC_W:1]};
            acc_lo_reg <= {partial[0], acc_lo_reg[MP_W-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = PROD_W'({acc_hi_reg, acc_lo_reg});

    `ASSERT_IMP(a_start_when_free, clk, rst_n, start, !busy_reg)
    `ASSERT_NXT(a_start_runs, clk, rst_n, start, busy_reg && (cnt_reg == '0))
    `ASSERT_IMP(a_done_after_run, clk, rst_n, done_reg, !busy_reg)

endmodule

`default_nettype wire

// ===== sv/heading_pi_bank_guidance_unit.sv =====
// Top level of the heading-select bank guidance unit. Each input beat is one guidance
// tick and gives exactly one output beat with the rate-limited bank reference
// (1/4096 rad). An inactive tick clears the heading integral and the remembered mode
// and returns zero; the first active tick seeds the reference from the measured roll
// clamped to the bank limit; a mode change clears the integral. In heading-select
// mode a PI term on the wrapped heading error gives the desired bank, otherwise the
// target roll does; the result is clamped and then slewed by at most
// roll_rate_limit * time_step. All products run through one bit-serial multiplier
// that takes the 16-bit operand one bit per cycle. An item needs four products in
// heading-select mode, one in other active modes and none on an inactive tick.
// Items are processed one at a time; the next input beat is taken as soon as the
// previous result sits in the output register, even if that result is still
// stalled. Configuration writes are always ready and must only be issued while
// the block is idle.
`default_nettype none
`include "assert_macros.svh"

module heading_pi_bank_guidance_unit (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Configuration write channel.
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [hpbg_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [hpbg_pkg::CFG_DATA_W-1:0]           cfg_data,
    // Input channel.
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      active,
    input  logic [hpbg_pkg::MODE_W-1:0]               mode,
    input  logic signed [hpbg_pkg::ROLL_W-1:0]        target_roll,
    input  logic [hpbg_pkg::HDG_W-1:0]                target_heading,
    input  logic                                      constrained,
    input  logic signed [hpbg_pkg::ROLL_W-1:0]        roll_measured,
    input  logic [hpbg_pkg::HDG_W-1:0]                heading_measured,
    input  logic [hpbg_pkg::DT_W-1:0]                 time_step,
    // Output channel.
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [hpbg_pkg::ROLL_W-1:0]        bank_reference
);
    import hpbg_pkg::*;

    // Configuration registers.
    logic [BLIM_W-1:0] blim_reg;
    logic [ILIM_W-1:0] ilim_reg;
    logic [GAIN_W-1:0] kp_reg;
    logic [GAIN_W-1:0] ki_reg;
    logic [RRL_W-1:0]  rrl_reg;

    // Controller state.
    state_t                   state_reg, state_next;
    logic                     was_active_reg, was_active_next;
    logic [MODE_W-1:0]        last_mode_reg, last_mode_next;
    logic signed [HI_W-1:0]   hi_reg, hi_next;
    logic signed [ROLL_W-1:0] bank_ref_reg, bank_ref_next;
    logic                     out_valid_reg, out_valid_next;

    // Captured input beat.
    logic                     active_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic signed [ROLL_W-1:0] target_roll_reg;
    logic [HDG_W-1:0]         target_heading_reg;
    logic                     constrained_reg;
    logic signed [ROLL_W-1:0] roll_measured_reg;
    logic [HDG_W-1:0]         heading_measured_reg;
    logic [DT_W-1:0]          time_step_reg;

    // Datapath registers.
    logic signed [ERR_W-1:0]  e_reg, e_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic signed [Q_W-1:0]    q_reg, q_next;
    logic signed [DES_W-1:0]  des_reg, des_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [ROLL_W-1:0] bank_reference_reg, bank_reference_next;

    logic in_take;

    // Serial multiplier hookup.
    logic                     mul_start;
    logic signed [MC_W-1:0]   mul_mcand;
    logic [MP_W-1:0]          mul_mplier;
    mul_stat_t                mul_stat;
    logic signed [PROD_W-1:0] mul_prod;

    // Combinational helpers.
    logic [HDG_W-1:0]         t_red, m_red;
    logic signed [HDG_W:0]    d_raw, d_wrap, half_s, full_s;
    logic signed [ERR_W-1:0]  e_calc;
    logic signed [ROLL_W-1:0] blim_r, roll_clamped;
    logic signed [HI_W-1:0]   ilim_h, hi_clamped;
    logic signed [Q_W-1:0]    blim_q, des_clamped;
    logic signed [SUM_W-1:0]  sum_rnd;
    logic [31:0]              step_sum;
    logic signed [LIM_W-1:0]  br_l, st_l, up_l, dn_l, des_l, lim_l;

    // Terms used by the checks at the end of the module.
    logic bank_ref_in_range;
    logic in_mul_state;
    logic out_load;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;

    // Configuration writes; indexes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blim_reg <= BLIM_RESET;
            ilim_reg <= ILIM_RESET;
            kp_reg   <= KP_RESET;
            ki_reg   <= KI_RESET;
            rrl_reg  <= RRL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BANK_LIMIT:     blim_reg <= cfg_data[BLIM_W-1:0];
                CFG_INTEGRAL_LIMIT: ilim_reg <= cfg_data[ILIM_W-1:0];
                CFG_GAIN_PROP:      kp_reg   <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_INTEG:     ki_reg   <= cfg_data[GAIN_W-1:0];
                CFG_ROLL_RATE:      rrl_reg  <= cfg_data[RRL_W-1:0];
                default:            ;
            endcase
        end
    end

    // Heading error: both headings are reduced below a full turn, and the difference
    // is wrapped into the half-open range of minus to plus half a turn.
    always_comb
    begin
        half_s = $signed({1'b0, HALF_TURN});
        full_s = $signed({1'b0, FULL_TURN});
        t_red  = (target_heading_reg >= FULL_TURN) ? target_heading_reg - FULL_TURN
                                                   : target_heading_reg;
        m_red  = (heading_measured_reg >= FULL_TURN) ? heading_measured_reg - FULL_TURN
                                                     : heading_measured_reg;
        d_raw  = $signed({1'b0, t_red}) - $signed({1'b0, m_red});
        if (d_raw >= half_s)
        begin
            d_wrap = d_raw - full_s;
        end
        else if (d_raw < -half_s)
        begin
            d_wrap = d_raw + full_s;
        end
        else
        begin
            d_wrap = d_raw;
        end
        e_calc = d_wrap[ERR_W-1:0];
    end

    // Symmetric clamps against the bank and integral limits.
    always_comb
    begin
        blim_r = signed'(ROLL_W'(blim_reg));
        if (roll_measured_reg > blim_r)
        begin
            roll_clamped = blim_r;
        end
        else if (roll_measured_reg < -blim_r)
        begin
            roll_clamped = -blim_r;
        end
        else
        begin
            roll_clamped = roll_measured_reg;
        end

        ilim_h = signed'(HI_W'(ilim_reg));
        if (hi_reg > ilim_h)
        begin
            hi_clamped = ilim_h;
        end
        else if (hi_reg < -ilim_h)
        begin
            hi_clamped = -ilim_h;
        end
        else
        begin
            hi_clamped = hi_reg;
        end

        blim_q = signed'(Q_W'(blim_reg));
        if (q_reg > blim_q)
        begin
            des_clamped = blim_q;
        end
        else if (q_reg < -blim_q)
        begin
            des_clamped = -blim_q;
        end
        else
        begin
            des_clamped = q_reg;
        end
    end

    // Rounding of the PI sum to 1/4096 rad (ties upward) and of the slew step.
    assign sum_rnd  = sum_reg + Q_ROUND;
    assign step_sum = {1'b0, mul_prod[30:0]} + STEP_ROUND;

    // Slew limit: the reference moves toward the desired bank by at most one step.
    always_comb
    begin
        br_l  = LIM_W'(bank_ref_reg);
        st_l  = signed'(LIM_W'(step_reg));
        des_l = LIM_W'(des_reg);
        up_l  = br_l + st_l;
        dn_l  = br_l - st_l;
        if (des_l > up_l)
        begin
            lim_l = up_l;
        end
        else if (des_l < dn_l)
        begin
            lim_l = dn_l;
        end
        else
        begin
            lim_l = des_l;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next          = state_reg;
        was_active_next     = was_active_reg;
        last_mode_next      = last_mode_reg;
        hi_next             = hi_reg;
        bank_ref_next       = bank_ref_reg;
        out_valid_next      = out_valid_reg && out_stall;
        e_next              = e_reg;
        sum_next            = sum_reg;
        q_next              = q_reg;
        des_next            = des_reg;
        step_next           = step_reg;
        bank_reference_next = bank_reference_reg;
        mul_start           = 1'b0;
        mul_mcand           = '0;
        mul_mplier          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (!active_reg)
                begin
                    hi_next         = '0;
                    was_active_next = 1'b0;
                    last_mode_next  = MODE_OFF;
                    state_next      = S_OUT;
                end
                else
                begin
                    if (!was_active_reg)
                    begin
                        bank_ref_next = roll_clamped;
                    end
                    was_active_next = 1'b1;
                    if (mode_reg != last_mode_reg)
                    begin
                        hi_next = '0;
                    end
                    last_mode_next = mode_reg;
                    e_next         = e_calc;
                    if (mode_reg == MODE_HDG)
                    begin
                        // Integral increment: error times time step.
                        mul_start  = 1'b1;
                        mul_mcand  = MC_W'(e_calc);
                        mul_mplier = time_step_reg;
                        state_next = S_MUL_ED;
                    end
                    else
                    begin
                        q_next     = Q_W'(target_roll_reg);
                        state_next = S_DCLAMP;
                    end
                end
            end
            S_MUL_ED:
            begin
                if (mul_stat.done)
                begin
                    if (!constrained_reg)
                    begin
                        hi_next = hi_reg + signed'(mul_prod[HI_W-1:0]);
                    end
                    state_next = S_ICLAMP;
                end
            end
            S_ICLAMP:
            begin
                // A frozen integral keeps its value, even beyond a lowered limit.
                if (!constrained_reg)
                begin
                    hi_next = hi_clamped;
                end
                mul_start  = 1'b1;
                mul_mcand  = MC_W'(e_reg);
                mul_mplier = kp_reg;
                state_next = S_MUL_PE;
            end
            S_MUL_PE:
            begin
                if (mul_stat.done)
                begin
                    sum_next   = mul_prod <<< PROP_SHIFT;
                    mul_start  = 1'b1;
                    mul_mcand  = hi_reg;
                    mul_mplier = ki_reg;
                    state_next = S_MUL_IH;
                end
            end
            S_MUL_IH:
            begin
                if (mul_stat.done)
                begin
                    sum_next   = sum_reg + mul_prod;
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                q_next     = Q_W'(sum_rnd >>> Q_SHIFT);
                state_next = S_DCLAMP;
            end
            S_DCLAMP:
            begin
                des_next   = des_clamped[DES_W-1:0];
                mul_start  = 1'b1;
                mul_mcand  = MC_W'(rrl_reg);
                mul_mplier = time_step_reg;
                state_next = S_MUL_ST;
            end
            S_MUL_ST:
            begin
                if (mul_stat.done)
                begin
                    step_next  = step_sum[31:16];
                    state_next = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                bank_ref_next = lim_l[ROLL_W-1:0];
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next      = 1'b1;
                    bank_reference_next = active_reg ? bank_ref_reg : '0;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            was_active_reg <= 1'b0;
            last_mode_reg  <= MODE_OFF;
            hi_reg         <= '0;
            bank_ref_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            was_active_reg <= was_active_next;
            last_mode_reg  <= last_mode_next;
            hi_reg         <= hi_next;
            bank_ref_reg   <= bank_ref_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            active_reg           <= active;
            mode_reg             <= mode;
            target_roll_reg      <= target_roll;
            target_heading_reg   <= target_heading;
            constrained_reg      <= constrained;
            roll_measured_reg    <= roll_measured;
            heading_measured_reg <= heading_measured;
            time_step_reg        <= time_step;
        end
        e_reg              <= e_next;
        sum_reg            <= sum_next;
        q_reg              <= q_next;
        des_reg            <= des_next;
        step_reg           <= step_next;
        bank_reference_reg <= bank_reference_next;
    end

    hpbg_serial_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    assign out_valid      = out_valid_reg;
    assign bank_reference = bank_reference_reg;

    assign bank_ref_in_range = (bank_ref_reg <= BANK_REF_MAX)
                            && (bank_ref_reg >= BANK_REF_MIN);
    assign in_mul_state      = (state_reg == S_MUL_ED) || (state_reg == S_MUL_PE)
                            || (state_reg == S_MUL_IH) || (state_reg == S_MUL_ST);
    assign out_load          = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    `ASSERT_NXT(a_accept_to_prep, clk, rst_n, in_take, state_reg == S_PREP)
    `ASSERT_IMP(a_bank_ref_range, clk, rst_n, was_active_reg, bank_ref_in_range)
    `ASSERT_IMP(a_mul_in_mul_state, clk, rst_n, mul_stat.busy, in_mul_state)
    `ASSERT_NXT(a_out_load, clk, rst_n, out_load, out_valid_reg && (state_reg == S_IDLE))

endmodule

`default_nettype wire
